// ===== rtl/sma_pkg.sv =====
// Shared types and constants for the simple moving average block.
// No dependencies; the files that use it refer to it by scoped names.
package sma_pkg;

  // Field and register widths.
  localparam int SAMPLE_W = 32;
  localparam int WIN_W    = 7;
  localparam int SUM_W    = 64;
  localparam int AVG_W    = 32;

  // Ring depth default.
  localparam int MAX_WINDOW_DEF = 64;

  // The divider retires two quotient bits per cycle.
  localparam int DIV_CYCLES = SUM_W / 2;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  typedef logic [ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW_LENGTH = reg_idx_t'(0);
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_FINISH
  } sma_state_t;

  typedef struct packed {
    logic accept;
    logic accum;
    logic div_step;
    logic out_load;
  } sma_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } sma_status_t;

endpackage

// ===== rtl/sma_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sma_regs.sv =====
// Configuration register file on an APB-style port: holds window_length.
// Depends on sma_pkg.
module sma_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sma_pkg::ADDR_W-1:0]   paddr,
  input  logic [sma_pkg::DATA_W-1:0]   pwdata,
  output logic [sma_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [sma_pkg::WIN_W-1:0]    window_length
);

  logic [sma_pkg::WIN_W-1:0] window_r;
  logic [sma_pkg::WIN_W-1:0] window_nxt;
  sma_pkg::reg_idx_t         reg_idx;
  logic                      wr_en;

  assign reg_idx = paddr[sma_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    window_nxt = window_r;
    if (wr_en && (reg_idx == sma_pkg::REG_WINDOW_LENGTH)) begin
      window_nxt = pwdata[sma_pkg::WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= sma_pkg::WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == sma_pkg::REG_WINDOW_LENGTH) begin
      prdata = sma_pkg::DATA_W'(window_r);
    end
  end

  assign pready        = 1'b1;
  assign window_length = window_r;

endmodule

// ===== rtl/sma_ctrl.sv =====
// Sequencing state machine: accept, accumulate, divide, hand over the result.
// Depends on sma_pkg.
module sma_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sma_pkg::sma_status_t status,
  output sma_pkg::sma_cmd_t    cmd
);

  sma_pkg::sma_state_t state_r;
  sma_pkg::sma_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sma_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sma_pkg::ST_ACCUM;
        end
      end
      sma_pkg::ST_ACCUM: begin
        state_nxt = sma_pkg::ST_DIV;
      end
      sma_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = sma_pkg::ST_FINISH;
        end
      end
      sma_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          state_nxt = sma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      sma_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      sma_pkg::ST_ACCUM: begin
        cmd.accum = 1'b1;
      end
      sma_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      sma_pkg::ST_FINISH: begin
        cmd.out_load = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sma_dp.sv =====
// Datapath: running sum, sample count, history ring, radix-4 restoring
// divider and output register. Depends on sma_pkg and sma_ram.
module sma_dp #(
  parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sma_pkg::sma_cmd_t             cmd,
  output sma_pkg::sma_status_t          status,
  input  logic [sma_pkg::WIN_W-1:0]     window_length,
  input  logic [sma_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          in_series_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sma_pkg::AVG_W-1:0]     out_average
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DIFF_W = ((SLOT_W + 1 > sma_pkg::WIN_W) ? SLOT_W + 1 : sma_pkg::WIN_W) + 1;
  localparam int WIN_W  = sma_pkg::WIN_W;
  localparam int SUM_W  = sma_pkg::SUM_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);

  // Architectural state.
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [WIN_W-1:0]  seen_r, seen_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // Captured input word.
  logic [sma_pkg::SAMPLE_W-1:0] sample_r;
  logic                         start_r;

  // Divider.
  logic [SUM_W-1:0]          qn_r, qn_nxt;
  logic [WIN_W-1:0]          rem_r, rem_nxt;
  logic [WIN_W-1:0]          divisor_r;
  logic [sma_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic [sma_pkg::AVG_W-1:0] out_avg_r;

  logic [WIN_W-1:0]             w_eff;
  logic [DIFF_W-1:0]            old_raw;
  logic [SLOT_W-1:0]            old_slot;
  logic [sma_pkg::SAMPLE_W-1:0] ring_rd;
  logic [SUM_W-1:0]             sum_base;
  logic [WIN_W-1:0]             seen_base;
  logic                         warm;
  logic [SUM_W-1:0]             leaving;

  // A zero window acts as one; anything above the ring depth is clamped.
  always_comb begin
    w_eff = window_length;
    if (window_length == '0) begin
      w_eff = WIN_W'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end
  end

  // Slot of the sample leaving the window, modulo the ring depth.
  always_comb begin
    old_raw = DIFF_W'(slot_r) + DIFF_W'(MAX_WINDOW) - DIFF_W'(w_eff);
    if (old_raw >= DIFF_W'(MAX_WINDOW)) begin
      old_raw = old_raw - DIFF_W'(MAX_WINDOW);
    end
    old_slot = old_raw[SLOT_W-1:0];
  end

  sma_ram #(
    .WIDTH (sma_pkg::SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.accum),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (cmd.accept),
    .rd_addr (old_slot),
    .rd_data (ring_rd)
  );

  always_comb begin
    sum_base  = start_r ? '0 : sum_r;
    seen_base = start_r ? '0 : seen_r;
    warm      = (seen_base < w_eff);
    leaving   = warm ? '0 : SUM_W'(ring_rd);
    sum_nxt   = sum_r;
    seen_nxt  = seen_r;
    slot_nxt  = slot_r;
    if (cmd.accum) begin
      sum_nxt  = sum_base + SUM_W'(sample_r) - leaving;
      seen_nxt = warm ? (seen_base + WIN_W'(1)) : seen_base;
      slot_nxt = (slot_r == LAST_SLOT) ? '0 : (slot_r + SLOT_W'(1));
    end
  end

  // Two restoring steps per cycle; the remainder stays below the divisor.
  always_comb begin
    logic [WIN_W:0]   t1;
    logic [WIN_W:0]   t2;
    logic             ge1;
    logic             ge2;
    logic [WIN_W-1:0] r1;
    t1  = {rem_r, qn_r[SUM_W-1]};
    ge1 = (t1 >= {1'b0, divisor_r});
    if (ge1) begin
      t1 = t1 - {1'b0, divisor_r};
    end
    r1  = t1[WIN_W-1:0];
    t2  = {r1, qn_r[SUM_W-2]};
    ge2 = (t2 >= {1'b0, divisor_r});
    if (ge2) begin
      t2 = t2 - {1'b0, divisor_r};
    end
    qn_nxt  = qn_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.accum) begin
      qn_nxt  = sum_nxt;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      qn_nxt  = {qn_r[SUM_W-3:0], ge1, ge2};
      rem_nxt = t2[WIN_W-1:0];
      cnt_nxt = cnt_r + sma_pkg::CNT_W'(1);
    end
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      seen_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      seen_r      <= seen_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      start_r  <= in_series_start;
    end
    if (cmd.accum) begin
      divisor_r <= warm ? (seen_base + WIN_W'(1)) : w_eff;
    end
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.out_load) begin
      out_avg_r <= qn_r[sma_pkg::AVG_W-1:0];
    end
  end

  assign status.div_last = (cnt_r == sma_pkg::CNT_W'(sma_pkg::DIV_CYCLES - 1));
  assign status.out_busy = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;

endmodule

// ===== rtl/simple_moving_average_top.sv =====
// Simple moving average: an accepted word is summed, divided and then loaded into
// the output register. One word is taken at a time, paced by the divider retiring
// two bits per cycle over the 64-bit running sum; out_stall can delay the next word.
// Synchronous active-low reset clears the sum, sample count, ring pointer, state
// machine and output valid, and sets window_length to 5; the ring is not cleared.
// Depends on sma_pkg, sma_regs, sma_ctrl, sma_dp and sma_ram.
module simple_moving_average_top #(
  parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sma_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_series_start,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sma_pkg::AVG_W-1:0]    out_average,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sma_pkg::ADDR_W-1:0]   paddr,
  input  logic [sma_pkg::DATA_W-1:0]   pwdata,
  output logic [sma_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  // The window length comes from the register file; the user must change it only while
  // the block is idle, which the block does not enforce. The datapath reads it directly.
  logic [sma_pkg::WIN_W-1:0] window_length;
  sma_pkg::sma_cmd_t         cmd;
  sma_pkg::sma_status_t      status;

  sma_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_length (window_length)
  );

  // The controller takes one word at a time: it reads the leaving sample from the
  // ring while capturing the word, updates the sum next cycle, then runs the
  // divider and finally moves the quotient into the output register. The output
  // register lets the next word in while an earlier result still waits.
  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath keeps the running sum modulo 2^64; a window change in the middle of a
  // series can leave the sum out of step with the window.
  sma_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .window_length   (window_length),
    .in_sample       (in_sample),
    .in_series_start (in_series_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average)
  );

endmodule

// ===== rtl/sma_checker.sv =====
// Port-level checks for the moving average top level, attached by bind.
// Depends on simple_moving_average_top and sma_pkg.
module sma_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [sma_pkg::AVG_W-1:0] out_average
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("stalled result word changed");

  // One word at a time: the block stalls its input after taking one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again too soon");

  // A new result only appears while a word was in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a word in flight");

endmodule

bind simple_moving_average_top sma_checker u_sma_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_average (out_average)
);

// ===== verif/tb_simple_moving_average_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for simple_moving_average_top: directed table, then random phases.
// Depends on sma_pkg and the RTL of simple_moving_average_top; it reads no files.
module tb_simple_moving_average_top;

  localparam int SAMPLE_W = sma_pkg::SAMPLE_W;
  localparam int AVG_W    = sma_pkg::AVG_W;
  localparam int WIN_W    = sma_pkg::WIN_W;
  localparam int ADDR_W   = sma_pkg::ADDR_W;
  localparam int DATA_W   = sma_pkg::DATA_W;

  localparam int PIPE_LATENCY = 34;
  localparam int RING_DEPTH   = sma_pkg::MAX_WINDOW_DEF;
  // Watchdog limit, with a wide margin over the length of a correct run.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int NUM_DIRECTED = 26;
  localparam int NUM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 104;

  // Idling modes, one per random phase in rotation.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // A directed row either writes window_length or sends one word.
  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;   // Sample, or the window_length for a ROW_CFG row.
    logic        start;
    logic        lit;     // 1 when the expected average is typed in below.
    logic [31:0] want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  in_series_start;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [AVG_W-1:0]      out_average;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  simple_moving_average_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_series_start(in_series_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Predictor state: our own copy of the configuration register, the running
  // sum, the count in the current series, the ring write pointer and the ring.
  logic [WIN_W-1:0]  window_reg;
  logic [63:0]       run_sum;
  logic [6:0]        seen_count;
  logic [5:0]        ring_wr_ptr;
  logic [31:0]       sample_ring [RING_DEPTH];

  // Averages still owed by the block, oldest first.
  logic [AVG_W-1:0]  avg_expected_q [$];

  int mismatch_count;
  int cycle_count = 0;
  int send_pct;
  int stall_pct;

  // The table starts in the reset window of 5. Literal results are the ones
  // that need no arithmetic: a fresh series, a window of one, equal samples.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h0002_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h0003_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h0004_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h0005_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h0006_0000, 1'b0, 1'b0, 32'h0},
    // Window shrinks to one in the middle of a full series.
    '{ROW_CFG,  32'd1,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'hDEAD_BEEF},
    '{ROW_ITEM, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0001},
    // A window of zero behaves as a window of one.
    '{ROW_CFG,  32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hCAFE_F00D, 1'b1, 1'b1, 32'hCAFE_F00D},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    // A window above the ring depth is clamped to the depth.
    '{ROW_CFG,  32'd127,       1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  32'd64,        1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    // Shrink mid-series while still warming up, then run into the steady rule.
    '{ROW_CFG,  32'd3,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0}
  };

  // Window values for the random phases, the extremes among them.
  function automatic logic [WIN_W-1:0] phase_window(input int phase);
    case (phase)
      0:       return WIN_W'(1);
      1:       return WIN_W'(64);
      2:       return WIN_W'(0);
      3:       return WIN_W'(127);
      4:       return WIN_W'(2);
      5:       return WIN_W'(5);
      6:       return WIN_W'(63);
      7:       return WIN_W'(65);
      9:       return WIN_W'($urandom_range(0, 127));
      10:      return WIN_W'(3);
      default: return WIN_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Zero acts as one and anything above the ring depth acts as the depth.
  function automatic logic [6:0] effective_window();
    if (window_reg == '0)
      return 7'd1;
    if (window_reg > WIN_W'(RING_DEPTH))
      return 7'(RING_DEPTH);
    return window_reg;
  endfunction

  // Advances the predictor by one accepted word and returns the average that
  // the block must produce for it.
  function automatic logic [AVG_W-1:0] predict_average(input logic [31:0] x,
                                                       input logic start);
    logic [6:0]  win;
    logic [63:0] divisor;
    logic [63:0] quotient;
    logic [5:0]  oldest;
    win = effective_window();
    if (start) begin
      run_sum    = '0;
      seen_count = '0;
    end
    if (seen_count < win) begin
      // Warm-up: divide by the count including this sample.
      run_sum    = run_sum + {32'b0, x};
      seen_count = seen_count + 7'd1;
      divisor    = {57'b0, seen_count};
    end else begin
      // Steady: the sample written win slots back leaves the window. For a
      // window equal to the ring depth that is the slot about to be written.
      oldest  = ring_wr_ptr - win[5:0];
      run_sum = run_sum + {32'b0, x} - {32'b0, sample_ring[oldest]};
      divisor = {57'b0, win};
    end
    sample_ring[ring_wr_ptr] = x;
    ring_wr_ptr = ring_wr_ptr + 6'd1;
    quotient = run_sum / divisor;
    return quotient[AVG_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s at cycle %0d: expected %h, actual %h",
               what, cycle_count, want, got);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_pct  = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_pct  = 74;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_pct  = 0;
        stall_pct = 74;
      end
      default: begin
        send_pct  = 16;
        stall_pct = 16;
      end
    endcase
  endtask

  // Sends one word. Valid stays high from the previous word unless an idle
  // gap is taken, so in_valid gets exactly one assignment per time step. Now
  // and then a long gap lets valid rise at any point of the divide.
  task automatic push_word(input logic [31:0] x, input logic start,
                           input logic lit, input logic [31:0] want);
    logic [AVG_W-1:0] predicted;
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      if ($urandom_range(15) == 0)
        repeat ($urandom_range(1, 40)) @(posedge clk);
      else
        @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= x;
    in_series_start <= start;
    do @(posedge clk); while (in_stall);
    predicted = predict_average(x, start);
    avg_expected_q.insert(avg_expected_q.size(), lit ? want : predicted);
  endtask

  // Drops valid, waits for every owed average, then lets the divider settle
  // so that a register write only ever meets an idle block.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (avg_expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // Writes window_length over the APB port, then reads it back. The upper
  // bits of pwdata are junk, and the register keeps only its low seven bits.
  task automatic write_window(input logic [WIN_W-1:0] win);
    logic [DATA_W-1:0] junk;
    junk    = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sma_pkg::REG_WINDOW_LENGTH, 2'b00};
    pwdata  <= {junk[DATA_W-1:WIN_W], win};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    window_reg = win;
    // Read back at the same address.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(DATA_W-WIN_W){1'b0}}, win})
      report_mismatch("window_length readback", {{(DATA_W-WIN_W){1'b0}}, win}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Samples lean toward the extremes and toward round Q16.16 values. Plain
  // $urandom values make sure that every bit is seen at both levels.
  function automatic logic [31:0] random_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return {16'b0, raw[15:0]};
      3:       return {raw[31:16], 16'b0};
      4:       return {raw[31:24], 24'hFF_FFFF};
      default: return raw;
    endcase
  endfunction

  // Receiver: stall on a fraction of cycles set by the current mode.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker. It samples at the clock edge, so it sees the values that
  // were settled before the edge on both sides of the handshake.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (avg_expected_q.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, out_average);
      end else begin
        if (out_average !== avg_expected_q[0])
          report_mismatch("average", avg_expected_q[0], out_average);
        void'(avg_expected_q.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_simple_moving_average_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          words_left;
    logic        start;
    logic [6:0]  win;
    // Every input is known from time zero, and reset starts low.
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample       = '0;
    in_series_start = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatch_count  = 0;
    window_reg      = sma_pkg::WINDOW_RESET;
    run_sum         = '0;
    seen_count      = '0;
    ring_wr_ptr     = '0;
    set_idling(IDLE_NONE);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. A register row first lets the block go idle.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        drain_block();
        write_window(directed_rows[r].value[WIN_W-1:0]);
      end else begin
        push_word(directed_rows[r].value, directed_rows[r].start,
                  directed_rows[r].lit, directed_rows[r].want);
      end
    end

    // Random phases. Each phase sets a window and an idling mode, then sends
    // series of random length. Most series run past the window into the
    // steady rule. A stray series start now and then breaks a series off
    // early. One phase in four keeps the old series across the window change.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      write_window(phase_window(p));
      set_idling(idle_mode_t'(p % 4));
      win        = effective_window();
      words_left = ((p % 4) == 3) ? int'($urandom_range(1, 3 * win + 4)) : 0;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        start = 1'b0;
        if (words_left == 0) begin
          start      = 1'b1;
          words_left = $urandom_range(1, 3 * win + 4);
        end else if ($urandom_range(39) == 0) begin
          start = 1'b1;
        end
        words_left--;
        push_word(random_sample(), start, 1'b0, '0);
      end
    end

    // Wait for the last averages and a quiet tail, then give the verdict.
    set_idling(IDLE_NONE);
    drain_block();
    if (mismatch_count == 0) begin
      $display("tb_simple_moving_average_top passed");
    end else begin
      $display("tb_simple_moving_average_top failed");
    end
    $finish;
  end

endmodule
